// ===== hw/rtl/fixed_point_quantization_loss_unit_assert.svh =====
// Assertion macros for the quantization loss unit.
// Used by the top level; no other dependencies.
`ifndef FIXED_POINT_QUANTIZATION_LOSS_UNIT_ASSERT_SVH
`define FIXED_POINT_QUANTIZATION_LOSS_UNIT_ASSERT_SVH

// same-cycle implication
`define FPQL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FPQL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/fpql_pkg.sv =====
// Shared constants and types for the quantization loss unit.
// No dependencies.
`default_nettype none

package fpql_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int INPUT_FRAC = 16;
	localparam int ACC_W      = 48;
	// largest error: the magnitude of a sample, at most 2^31, below 2^33
	localparam int ERR_W      = 34;
	// beyond this shift every sample rounds to zero
	localparam int SHIFT_CAP  = 34;

	localparam int BW_W    = 5;
	localparam int FL_W    = 6;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_BIT_WIDTH   = 2'd0,
		REG_FRAC_LENGTH = 2'd1,
		REG_IS_SIGNED   = 2'd2
	} reg_idx_t;

	// frac_length holds two's complement bits
	typedef struct packed {
		logic [BW_W-1:0] bit_width;
		logic [FL_W-1:0] frac_length;
		logic            is_signed;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fpql_err_calc.sv =====
// Absolute quantization error of one sample against the configured format.
// Depends on fpql_pkg.
`default_nettype none

module fpql_err_calc import fpql_pkg::*; (
	input  logic [SAMPLE_W-1:0] sample,
	input  cfg_t                cfg,
	output logic [ERR_W-1:0]    err
);

	logic [BW_W-1:0]     bw_eff;
	logic [SAMPLE_W-1:0] qmax;
	logic [SAMPLE_W-1:0] mneg;
	logic [SAMPLE_W-1:0] bound;
	logic [SAMPLE_W-1:0] mag;
	logic                neg;
	logic [6:0]          shift_s;
	logic [6:0]          shift_n;
	logic [5:0]          sh;
	logic [ERR_W-1:0]    half_r;
	logic [ERR_W-1:0]    qm;
	logic [ERR_W-1:0]    qc;
	logic [ERR_W-1:0]    rm;
	logic [ERR_W:0]      diff;
	logic [ERR_W-1:0]    err_coarse;
	logic [3:0]          t;
	logic [SAMPLE_W-1:0] thr;
	logic [SAMPLE_W-1:0] frac_mask;
	logic [SAMPLE_W-1:0] frac;
	logic [SAMPLE_W-1:0] half_t;
	logic [ERR_W-1:0]    err_fine;

	always_comb begin
		bw_eff = (cfg.is_signed && cfg.bit_width == '0) ? BW_W'(1) : cfg.bit_width;
		if (cfg.is_signed) begin
			mneg = SAMPLE_W'(1) << (bw_eff - 1'b1);
			qmax = mneg - 1'b1;
		end else begin
			mneg = '0;
			qmax = (SAMPLE_W'(1) << cfg.bit_width) - 1'b1;
		end

		neg   = sample[SAMPLE_W-1];
		mag   = neg ? (~sample + 1'b1) : sample;
		bound = neg ? mneg : qmax;

		// grid exponent relative to the input LSB
		shift_s = 7'(INPUT_FRAC) - {cfg.frac_length[FL_W-1], cfg.frac_length};
		shift_n = 7'd0 - shift_s;

		// coarse grid: round magnitude half away from zero, clamp, rebuild
		sh     = (shift_s[5:0] > 6'(SHIFT_CAP)) ? 6'(SHIFT_CAP) : shift_s[5:0];
		half_r = (sh == '0) ? '0 : (ERR_W'(1) << (sh - 1'b1));
		qm     = (ERR_W'(mag) + half_r) >> sh;
		qc     = (qm > ERR_W'(bound)) ? ERR_W'(bound) : qm;
		rm     = qc << sh;
		diff   = (ERR_W+1)'(rm) - (ERR_W+1)'(mag);
		err_coarse = diff[ERR_W] ? ERR_W'(~diff + 1'b1) : diff[ERR_W-1:0];

		// fine grid: only a clamped sample has error, rounded to an input LSB
		t         = shift_n[3:0];
		thr       = bound >> t;
		frac_mask = (SAMPLE_W'(1) << t) - 1'b1;
		frac      = bound & frac_mask;
		half_t    = SAMPLE_W'(1) << (t - 1'b1);
		if (mag > thr) begin
			err_fine = ERR_W'(mag) - ERR_W'(thr) - ((frac > half_t) ? ERR_W'(1) : ERR_W'(0));
		end else begin
			err_fine = '0;
		end

		err = shift_s[6] ? err_fine : err_coarse;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_point_quantization_loss_unit.sv =====
// An accepted word passes the input register and then the error stage before its total reaches the result register.
// Throughput: one word per cycle while the result side takes each total in turn.
// A stalled total holds the error stage only while it carries a word marked last,
// and then the input register behind it as well, whatever that word is.
// Reset clears the accumulator and all valid bits and loads bit_width 8, frac_length 0,
// is_signed 1.
`default_nettype none
`include "fixed_point_quantization_loss_unit_assert.svh"

module fixed_point_quantization_loss_unit import fpql_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                last,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [ACC_W-1:0]    total_loss
);

	cfg_t                cfg_q;
	reg_idx_t            reg_idx;
	logic                cfg_wr;

	logic                v_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                last_s1;
	logic                v_s2;
	logic [ERR_W-1:0]    err_s2;
	logic                last_s2;
	logic [ERR_W-1:0]    err_calc;

	logic [ACC_W-1:0]    acc_q;
	logic [ACC_W:0]      acc_sum;
	logic [ACC_W-1:0]    acc_next;
	logic                out_valid_q;
	logic [ACC_W-1:0]    total_loss_q;

	logic                out_free;
	logic                s2_adv;
	logic                s1_adv;
	logic                s2_accum;
	logic                s2_close;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_width   <= BW_W'(8);
			cfg_q.frac_length <= '0;
			cfg_q.is_signed   <= 1'b1;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_BIT_WIDTH:   cfg_q.bit_width   <= pwdata[BW_W-1:0];
				REG_FRAC_LENGTH: cfg_q.frac_length <= pwdata[FL_W-1:0];
				REG_IS_SIGNED:   cfg_q.is_signed   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BIT_WIDTH:   prdata = PDATA_W'(cfg_q.bit_width);
			REG_FRAC_LENGTH: prdata = PDATA_W'(cfg_q.frac_length);
			REG_IS_SIGNED:   prdata = PDATA_W'(cfg_q.is_signed);
			default:         prdata = '0;
		endcase
	end

	// flow control: only a last word needs the result register
	assign out_free = !out_valid_q || !out_stall;
	assign s2_adv   = !v_s2 || !last_s2 || out_free;
	assign s1_adv   = !v_s1 || s2_adv;
	assign in_stall = !s1_adv;

	assign s2_accum = v_s2 && !last_s2 && s2_adv;
	assign s2_close = v_s2 && last_s2 && s2_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_adv) begin
				v_s1 <= in_valid;
			end
			if (s2_adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && in_valid) begin
			sample_s1 <= sample;
			last_s1   <= last;
		end
		if (s2_adv && v_s1) begin
			err_s2  <= err_calc;
			last_s2 <= last_s1;
		end
	end

	fpql_err_calc u_err_calc (
		.sample (sample_s1),
		.cfg    (cfg_q),
		.err    (err_calc)
	);

	// saturating accumulate
	assign acc_sum  = (ACC_W+1)'(acc_q) + (ACC_W+1)'(err_s2);
	assign acc_next = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (v_s2 && s2_adv) begin
				acc_q <= last_s2 ? '0 : acc_next;
			end
			if (out_free) begin
				out_valid_q <= v_s2 && last_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s2 && last_s2) begin
			total_loss_q <= acc_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign total_loss = total_loss_q;

	`FPQL_ASSERT_NXT(a_acc_clear_on_last, clk, arst_n, s2_close, acc_q == '0, "acc not cleared")
	`FPQL_ASSERT_NXT(a_acc_no_wrap, clk, arst_n, s2_accum, acc_q >= $past(acc_q), "acc wrapped")
	`FPQL_ASSERT_IMP(a_result_from_last, clk, arst_n, $rose(out_valid_q), $past(s2_close), "stray total")

endmodule

`default_nettype wire

// ===== bench/fpql_loss_checker.sv =====
// Checker for the quantization loss unit: follows register writes, predicts
// each blob's total loss and compares it with the result channel.
// Depends on fpql_pkg for widths, the register map and cfg_t.
`default_nettype none

module fpql_loss_checker import fpql_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                last,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [ACC_W-1:0]    total_loss,
	output int                  errors,
	output int                  pending,
	output int                  totals_checked,
	output int                  blocked_cycles
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint LOSS_MAX   = (longint'(1) << ACC_W) - 1;
	localparam int     PRINT_CAP  = 40;

	cfg_t             cfg;
	longint           running_loss;
	logic [ACC_W-1:0] expected_totals[$];

	task automatic report(input string msg);
		errors++;
		if (errors <= PRINT_CAP)
			$display("%0t: total loss mismatch: %s", $time, msg);
	endtask

	// error of a sample clipped down to b / 2^t, rounded to input LSBs, ties toward zero
	function automatic longint clip_error(input longint v, input longint b, input int t);
		longint k;
		longint frac;
		longint half;
		k = v - (b >>> t);
		frac = b & ((longint'(1) << t) - 1);
		half = longint'(1) << (t - 1);
		if (frac > half)
			k = k - 1;
		return k;
	endfunction

	// absolute error of one sample against the current target format
	function automatic longint grid_error(input longint x, input cfg_t c);
		int     bw;
		int     s;
		longint qmax;
		longint mneg;
		longint q;
		longint m;
		longint d;
		bw = int'(c.bit_width);
		s = INPUT_FRAC - int'($signed(c.frac_length));
		if (c.is_signed) begin
			if (bw == 0)
				bw = 1;
			qmax = (longint'(1) << (bw - 1)) - 1;
			mneg = longint'(1) << (bw - 1);
		end else begin
			qmax = (longint'(1) << bw) - 1;
			mneg = 0;
		end
		if (s >= 0) begin
			if (s == 0) begin
				q = x;
			end else begin
				m = (x < 0) ? -x : x;
				q = (m + (longint'(1) << (s - 1))) >>> s;
				if (x < 0)
					q = -q;
			end
			if (q > qmax)
				q = qmax;
			if (q < -mneg)
				q = -mneg;
			d = x - (q <<< s);
			return (d < 0) ? -d : d;
		end
		// grid finer than the input LSB: only clipped samples lose anything
		if (x > (qmax >>> -s))
			return clip_error(x, qmax, -s);
		if (-x > (mneg >>> -s))
			return clip_error(-x, mneg, -s);
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint           err;
		logic [ACC_W-1:0] want;
		if (!arst_n) begin
			cfg.bit_width = 5'd8;
			cfg.frac_length = '0;
			cfg.is_signed = 1'b1;
			running_loss = 0;
			expected_totals.delete();
			errors = 0;
			pending = 0;
			totals_checked = 0;
			blocked_cycles = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_BIT_WIDTH: cfg.bit_width = pwdata[BW_W-1:0];
					REG_FRAC_LENGTH: cfg.frac_length = pwdata[FL_W-1:0];
					REG_IS_SIGNED: cfg.is_signed = pwdata[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				totals_checked++;
				if (expected_totals.size() == 0) begin
					report($sformatf("total 0x%012h arrived with none outstanding", total_loss));
				end else begin
					want = expected_totals.pop_front();
					if (total_loss !== want)
						report($sformatf("got 0x%012h, want 0x%012h", total_loss, want));
				end
			end
			if (in_valid && in_stall)
				blocked_cycles++;
			if (in_valid && !in_stall) begin
				err = grid_error(longint'($signed(sample)), cfg);
				// saturate and hold until the blob closes
				if (err > LOSS_MAX - running_loss)
					running_loss = LOSS_MAX;
				else
					running_loss = running_loss + err;
				if (last) begin
					expected_totals = {expected_totals, running_loss[ACC_W-1:0]};
					running_loss = 0;
				end
			end
			pending = expected_totals.size();
		end
	end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Top of the quantization loss unit bench: clock, reset, register writes,
// sample stimulus and output stall pattern, with the verdict at the end.
// Depends on fpql_pkg, fpql_loss_checker and the unit itself.
`default_nettype none

module testbench;
	import fpql_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_SPARE   = 2'd3;  // unmapped slot, writes must be dropped
	localparam int         PIPE_DEPTH  = 4;
	localparam int         HOLD_CYCLES = 60;
	localparam int         RAND_PHASES = 12;
	localparam int         PHASE_WORDS = 88;
	localparam longint     SMP_TOP     = 64'sd2147483647;
	localparam longint     SMP_BOTTOM  = -64'sd2147483648;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;
	typedef enum int {
		KIND_RAW, KIND_SCALED, KIND_NEAR_TOP, KIND_NEAR_BOTTOM, KIND_TIE, KIND_SMALL
	} sample_kind_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic                in_valid = 1'b0;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                last = 1'b0;
	logic                out_stall = 1'b0;
	wire  [PDATA_W-1:0]  prdata;
	wire                 pready;
	wire                 in_stall;
	wire                 out_valid;
	wire  [ACC_W-1:0]    total_loss;

	int errors;
	int pending;
	int totals_checked;
	int blocked_cycles;

	bit hold_req = 1'b0;
	int words_sent = 0;
	int cfg_phases = 0;
	int burst_left = 0;
	int cur_bw = 8;
	int cur_fl = 0;
	bit cur_sgn = 1'b1;

	fixed_point_quantization_loss_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last(last),
		.out_valid(out_valid), .out_stall(out_stall), .total_loss(total_loss)
	);

	fpql_loss_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last(last),
		.out_valid(out_valid), .out_stall(out_stall), .total_loss(total_loss),
		.errors(errors), .pending(pending), .totals_checked(totals_checked),
		.blocked_cycles(blocked_cycles)
	);

	always #4 clk = ~clk;

	initial begin
		#4_000_000;
		$display("fixed_point_quantization_loss_unit test failed");
		$finish;
	end

	task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// stop offering words until every open blob has been totaled
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		// non-last words may still sit in the pipeline
		repeat (PIPE_DEPTH) @(negedge clk);
	endtask

	task automatic set_format(input int bw, input int fl, input bit sgn);
		logic [PDATA_W-1:0] v;
		drain();
		v = $urandom();
		v[BW_W-1:0] = bw[BW_W-1:0];
		write_reg(REG_BIT_WIDTH, v);
		v = $urandom();
		v[FL_W-1:0] = fl[FL_W-1:0];
		write_reg(REG_FRAC_LENGTH, v);
		v = $urandom();
		v[0] = sgn;
		write_reg(REG_IS_SIGNED, v);
		cur_bw = bw;
		cur_fl = fl;
		cur_sgn = sgn;
		cfg_phases++;
	endtask

	task automatic send(input logic [SAMPLE_W-1:0] s, input logic l, input bit paced = 1'b1);
		int gap;
		in_valid <= 1'b1;
		sample <= s;
		last <= l;
		do @(posedge clk); while (in_stall);
		words_sent++;
		@(negedge clk);
		if (paced) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end
	endtask

	// bias samples toward range limits and rounding ties of the current format
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int           s;
		longint       qmax;
		longint       mneg;
		longint       hi;
		longint       lo;
		longint       v;
		sample_kind_t kind;
		s = INPUT_FRAC - cur_fl;
		if (cur_sgn)
			qmax = (longint'(1) << ((cur_bw == 0) ? 0 : cur_bw - 1)) - 1;
		else
			qmax = (longint'(1) << cur_bw) - 1;
		mneg = cur_sgn ? qmax + 1 : 0;
		if (s > 32) begin
			hi = SMP_TOP;
			lo = SMP_BOTTOM;
		end else if (s >= 0) begin
			hi = qmax <<< s;
			lo = -(mneg <<< s);
		end else begin
			hi = qmax >>> -s;
			lo = -(mneg >>> -s);
		end
		kind = sample_kind_t'($urandom_range(0, 5));
		case (kind)
			KIND_RAW: v = longint'($signed($urandom()));
			KIND_SCALED: v = longint'($signed($urandom())) >>> $urandom_range(0, 31);
			KIND_NEAR_TOP: v = hi + int'($urandom_range(0, 64)) - 32;
			KIND_NEAR_BOTTOM: v = lo + int'($urandom_range(0, 64)) - 32;
			KIND_TIE: begin
				if (s >= 1 && s <= 31) begin
					v = (longint'($urandom_range(0, 255)) <<< s) + (longint'(1) <<< (s - 1));
					if ($urandom_range(0, 1))
						v = -v;
				end else begin
					v = int'($urandom_range(0, 15));
				end
			end
			default: v = int'($urandom_range(0, 512)) - 256;
		endcase
		if (v > SMP_TOP)
			v = SMP_TOP;
		if (v < SMP_BOTTOM)
			v = SMP_BOTTOM;
		return v[SAMPLE_W-1:0];
	endfunction

	// output stall: shifting patterns, or one long hold-off on request
	initial begin
		stall_mode_t mode;
		int          left;
		mode = STALL_NONE;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				if (left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					left = $urandom_range(20, 80);
				end
				left--;
				case (mode)
					STALL_NONE: out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	initial begin
		int bw_corners[5];
		int fl_corners[6];
		int bw;
		int fl;
		int n;
		int len;
		bw_corners = '{0, 1, 2, 24, 31};
		fl_corners = '{-32, -16, 0, 16, 17, 31};
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset format: 8-bit signed integers
		send(32'h0000_0000, 1'b0);
		send(32'h0000_8000, 1'b0);
		send(32'hFFFF_8000, 1'b0);
		send(32'h0001_8000, 1'b0);
		send(32'h007F_8000, 1'b0);
		send(32'hFF7F_8000, 1'b0);
		send(32'h7FFF_FFFF, 1'b0);
		send(32'h8000_0000, 1'b1);
		send(32'hFFFF_FFFF, 1'b1);
		drain();
		write_reg(REG_SPARE, $urandom());
		send(32'h0000_C000, 1'b1);

		// grid finer than an input LSB
		set_format(8, 20, 1'b1);
		send(32'h0000_0003, 1'b0);
		send(32'h0008_0000, 1'b0);
		send(32'h8000_0000, 1'b1);
		set_format(8, 17, 1'b1);
		send(32'h0000_0040, 1'b1);
		send(32'hFFFF_FFBF, 1'b1);
		set_format(24, 31, 1'b0);
		send(32'h7FFF_FFFF, 1'b0);
		send(32'hFFFF_FFFF, 1'b1);

		// very coarse grid
		set_format(31, -32, 1'b1);
		send(32'h7FFF_FFFF, 1'b0);
		send(32'h8000_0000, 1'b1);

		// zero bit width, both modes
		set_format(0, 4, 1'b0);
		send(32'h1234_5678, 1'b0);
		send(32'hFFFF_0001, 1'b1);
		set_format(0, 0, 1'b1);
		send(32'h0001_0000, 1'b0);
		send(32'hFFFF_0000, 1'b1);

		// largest single-word error, one blob per word
		set_format(0, 0, 1'b0);
		send(32'h8000_0000, 1'b1);
		send(32'h0001_0000, 1'b1);

		for (int p = 0; p < RAND_PHASES; p++) begin
			bw = ($urandom_range(0, 2) == 0) ? bw_corners[$urandom_range(0, 4)]
				: $urandom_range(0, 31);
			fl = ($urandom_range(0, 2) == 0) ? fl_corners[$urandom_range(0, 5)]
				: int'($urandom_range(0, 63)) - 32;
			set_format(bw, fl, 1'($urandom_range(0, 1)));
			if (p == 3) begin
				// long output hold-off while every word closes a blob
				hold_req = 1'b1;
				repeat (16) send(pick_sample(), 1'b1);
			end
			n = 0;
			while (n < PHASE_WORDS) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
				for (int i = 1; i <= len; i++)
					send(pick_sample(), i == len);
				n += len;
			end
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (2 * PIPE_DEPTH) @(posedge clk);

		$display("Sent %0d samples over %0d target formats; %0d loss totals compared.",
			words_sent, cfg_phases, totals_checked);
		$display("Input was held back for %0d cycles by output stalls.", blocked_cycles);
		if (errors == 0 && pending == 0)
			$display("fixed_point_quantization_loss_unit test passed");
		else
			$display("fixed_point_quantization_loss_unit test failed");
		$finish;
	end

endmodule

`default_nettype wire
